// File: hdl/acbi_pkg.sv
// Shared widths, register codes, payload types and the step function of the index unit.
package acbi_pkg;

  localparam int unsigned IDX_W   = 26;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned SEG_W   = 21;
  localparam int unsigned LANES_W = 5;
  localparam int unsigned LEN_W   = SEG_W + 2;
  localparam int unsigned LANE_W  = IDX_W - 2;
  localparam int unsigned SLICE_W = 2;

  // Block index divider: four quotient bits a stage
  localparam int unsigned DIV_STAGES = 7;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_PAD_W  = DIV_STAGES * DIV_BITS;
  // Lane selector reduction: five bits a stage, same stage count
  localparam int unsigned MOD_BITS   = 5;
  localparam int unsigned MOD_PAD_W  = DIV_STAGES * MOD_BITS;
  // Relative position reduction modulo lane length
  localparam int unsigned WRAP_STAGES = 8;
  localparam int unsigned WRAP_BITS   = HALF_W / WRAP_STAGES;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SEG_W;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT     = 1'b1;
  localparam logic [SEG_W-1:0]     SEG_RESET          = 21'd262144;
  localparam logic [LANES_W-1:0]   LANES_RESET        = 5'd4;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 56;

  // Divider stage payload
  typedef struct packed {
    logic [IDX_W-1:0]     ij;
    logic [HALF_W-1:0]    rand32;
    logic [MOD_PAD_W-1:0] hi;
    logic [DIV_PAD_W-1:0] div_num;
    logic [DIV_PAD_W-1:0] quo;
    logic [SEG_W-1:0]     rem_d;
    logic [LANES_W-1:0]   rem_m;
  } split_t;

  // Decomposed block index
  typedef struct packed {
    logic [IDX_W-1:0]   ij;
    logic [HALF_W-1:0]  rand32;
    logic [LANE_W-1:0]  lane;
    logic [SLICE_W-1:0] slice;
    logic [SEG_W-1:0]   pos;
    logic [LANES_W-1:0] rem_m;
  } idx_t;

  // Unreduced relative position with its base
  typedef struct packed {
    logic [IDX_W-1:0]  prev;
    logic [IDX_W-1:0]  base;
    logic [HALF_W-1:0] rel;
  } rel_t;

  // One restoring step group of both dividers
  function automatic split_t split_step(split_t s, logic [SEG_W-1:0] seg,
                                        logic [LANES_W-1:0] lanes);
    split_t           r;
    logic [SEG_W:0]   td;
    logic [LANES_W:0] tm;
    r = s;
    for (int b = 0; b < DIV_BITS; b++) begin
      td = {r.rem_d, r.div_num[DIV_PAD_W-1]};
      r.div_num = r.div_num << 1;
      if (td >= {1'b0, seg}) begin
        td = td - {1'b0, seg};
        r.quo = {r.quo[DIV_PAD_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[DIV_PAD_W-2:0], 1'b0};
      end
      r.rem_d = td[SEG_W-1:0];
    end
    for (int b = 0; b < MOD_BITS; b++) begin
      tm = {r.rem_m, r.hi[MOD_PAD_W-1]};
      r.hi = r.hi << 1;
      if (tm >= {1'b0, lanes}) begin
        tm = tm - {1'b0, lanes};
      end
      r.rem_m = tm[LANES_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/acbi_split.sv
// Pipelined dividers: block index by segment length, lane selector by lane count.
module acbi_split (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [acbi_pkg::SEG_W-1:0]  seg_i,
  input  logic [acbi_pkg::LANES_W-1:0] lanes_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [acbi_pkg::IDX_W-1:0]  ij_i,
  input  logic [acbi_pkg::WORD_W-1:0] word_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output acbi_pkg::idx_t              idx_o
);
  import acbi_pkg::*;

  split_t            st_q  [DIV_STAGES];
  split_t            st_d  [DIV_STAGES];
  split_t            st_in [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES:0]   en;
  logic [DIV_PAD_W-1:0]  quo;

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[DIV_STAGES] = ready_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Stage inputs and step logic
  always_comb begin
    st_in[0].ij      = ij_i;
    st_in[0].rand32  = word_i[HALF_W-1:0];
    st_in[0].hi      = {{(MOD_PAD_W-HALF_W){1'b0}}, word_i[WORD_W-1:HALF_W]};
    st_in[0].div_num = {{(DIV_PAD_W-IDX_W){1'b0}}, ij_i};
    st_in[0].quo     = '0;
    st_in[0].rem_d   = '0;
    st_in[0].rem_m   = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      st_d[k] = split_step(st_in[k], seg_i, lanes_i);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Quotient splits into lane and slice
  assign quo          = st_q[DIV_STAGES-1].quo;
  assign idx_o.ij     = st_q[DIV_STAGES-1].ij;
  assign idx_o.rand32 = st_q[DIV_STAGES-1].rand32;
  assign idx_o.lane   = quo[IDX_W-1:SLICE_W];
  assign idx_o.slice  = quo[SLICE_W-1:0];
  assign idx_o.pos    = st_q[DIV_STAGES-1].rem_d;
  assign idx_o.rem_m  = st_q[DIV_STAGES-1].rem_m;
  assign valid_o      = v_q[DIV_STAGES-1];
  assign ready_o      = en[0];

endmodule

// File: hdl/acbi_area.sv
// Reference area size, squared reduction and lane base, three stages.
module acbi_area (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [acbi_pkg::SEG_W-1:0]  seg_i,
  input  logic [acbi_pkg::LEN_W-1:0]  lane_len_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  acbi_pkg::idx_t              idx_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output acbi_pkg::rel_t              rel_o
);
  import acbi_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  prev;
    logic [LANE_W-1:0] tgt_lane;
    logic [HALF_W-1:0] area;
    logic [HALF_W-1:0] sq_hi;
  } a1_t;

  typedef struct packed {
    logic [IDX_W-1:0]  prev;
    logic [LANE_W-1:0] tgt_lane;
    logic [HALF_W-1:0] area_m1;
    logic [HALF_W-1:0] scaled;
  } a2_t;

  a1_t  a1_d, a1_q;
  a2_t  a2_d, a2_q;
  rel_t a3_d, a3_q;
  logic [2:0] v_q;
  logic [3:0] en;

  logic [LANE_W-1:0]   tgt_lane;
  logic [HALF_W-1:0]   slice_base;
  logic [HALF_W-1:0]   pos32;
  logic [2*HALF_W-1:0] sq;
  logic [2*HALF_W-1:0] prod;

  always_comb begin
    en[3] = ready_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Stage 1: lane choice, area size, previous index, square of the random half
  always_comb begin
    pos32 = {{(HALF_W-SEG_W){1'b0}}, idx_i.pos};
    if (idx_i.slice == '0) begin
      tgt_lane = idx_i.lane;
    end else begin
      tgt_lane = {{(LANE_W-LANES_W){1'b0}}, idx_i.rem_m};
    end
    case (idx_i.slice)
      2'd0:    slice_base = '0;
      2'd1:    slice_base = {{(HALF_W-SEG_W){1'b0}}, seg_i};
      2'd2:    slice_base = {{(HALF_W-SEG_W-1){1'b0}}, seg_i, 1'b0};
      default: slice_base = {{(HALF_W-SEG_W-1){1'b0}}, seg_i, 1'b0}
                            + {{(HALF_W-SEG_W){1'b0}}, seg_i};
    endcase
    if (idx_i.slice == '0) begin
      a1_d.area = pos32 - 32'd1;
    end else if (tgt_lane == idx_i.lane) begin
      a1_d.area = slice_base + pos32 - 32'd1;
    end else begin
      a1_d.area = slice_base + ((idx_i.pos == '0) ? 32'hFFFF_FFFF : 32'd0);
    end
    // first block of a lane wraps to the last block of the same lane
    if (idx_i.slice == '0 && idx_i.pos == '0) begin
      a1_d.prev = idx_i.ij + {{(IDX_W-LEN_W){1'b0}}, lane_len_i} - 26'd1;
    end else begin
      a1_d.prev = idx_i.ij - 26'd1;
    end
    sq             = idx_i.rand32 * idx_i.rand32;
    a1_d.sq_hi     = sq[2*HALF_W-1:HALF_W];
    a1_d.tgt_lane  = tgt_lane;
  end

  // Stage 2: scale the area by the squared value
  always_comb begin
    prod          = a1_q.area * a1_q.sq_hi;
    a2_d.prev     = a1_q.prev;
    a2_d.tgt_lane = a1_q.tgt_lane;
    a2_d.area_m1  = a1_q.area - 32'd1;
    a2_d.scaled   = prod[2*HALF_W-1:HALF_W];
  end

  // Stage 3: count back from the area end, lane base
  always_comb begin
    a3_d.prev = a2_q.prev;
    a3_d.rel  = a2_q.area_m1 - a2_q.scaled;
    a3_d.base = {{(IDX_W-LEN_W){1'b0}}, lane_len_i}
                * {{(IDX_W-LANE_W){1'b0}}, a2_q.tgt_lane};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) a1_q <= a1_d;
    if (en[1]) a2_q <= a2_d;
    if (en[2]) a3_q <= a3_d;
  end

  assign rel_o   = a3_q;
  assign valid_o = v_q[2];
  assign ready_o = en[0];

endmodule

// File: hdl/acbi_wrap.sv
// Relative position modulo lane length and final reference index register.
module acbi_wrap (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [acbi_pkg::LEN_W-1:0] lane_len_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  acbi_pkg::rel_t             rel_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [acbi_pkg::IDX_W-1:0] prev_o,
  output logic [acbi_pkg::IDX_W-1:0] ref_o
);
  import acbi_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  prev;
    logic [IDX_W-1:0]  base;
    logic [HALF_W-1:0] num;
    logic [LEN_W-1:0]  rem;
  } w_t;

  w_t w_q  [WRAP_STAGES];
  w_t w_d  [WRAP_STAGES];
  w_t w_in [WRAP_STAGES];
  logic [WRAP_STAGES:0]   v_q;
  logic [WRAP_STAGES+1:0] en;
  logic [IDX_W-1:0] prev_q, ref_q;
  logic [LEN_W:0]   t;

  always_comb begin
    en[WRAP_STAGES+1] = ready_i;
    for (int k = WRAP_STAGES; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Restoring remainder steps
  always_comb begin
    w_in[0].prev = rel_i.prev;
    w_in[0].base = rel_i.base;
    w_in[0].num  = rel_i.rel;
    w_in[0].rem  = '0;
    for (int k = 1; k < WRAP_STAGES; k++) begin
      w_in[k] = w_q[k-1];
    end
    t = '0;
    for (int k = 0; k < WRAP_STAGES; k++) begin
      w_d[k] = w_in[k];
      for (int b = 0; b < WRAP_BITS; b++) begin
        t = {w_d[k].rem, w_d[k].num[HALF_W-1]};
        w_d[k].num = w_d[k].num << 1;
        if (t >= {1'b0, lane_len_i}) begin
          t = t - {1'b0, lane_len_i};
        end
        w_d[k].rem = t[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k <= WRAP_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < WRAP_STAGES; k++) begin
      if (en[k]) begin
        w_q[k] <= w_d[k];
      end
    end
    // output register: lane base plus reduced position
    if (en[WRAP_STAGES]) begin
      prev_q <= w_q[WRAP_STAGES-1].prev;
      ref_q  <= w_q[WRAP_STAGES-1].base
                + {{(IDX_W-LEN_W){1'b0}}, w_q[WRAP_STAGES-1].rem};
    end
  end

  assign prev_o  = prev_q;
  assign ref_o   = ref_q;
  assign valid_o = v_q[WRAP_STAGES];
  assign ready_o = en[0];

endmodule

// File: hdl/argon2_reference_block_index.sv
// Top level of the first-pass reference block index unit.
// Usage:
//   Input stream (s_axis_*): one beat per block, carrying the global block
//   index and the first 64-bit word of the previous block.
//   Output stream (m_axis_*): one beat per input beat, in order, carrying the
//   previous block index (lane-wrapped) and the referenced block index.
//   Configuration: segment length (index 0) and lane count (index 1) are
//   written through cfg_we_i / cfg_idx_i / cfg_data_i while the unit is idle;
//   a value of zero is taken as one.
// Timing:
//   Seven divider stages (index by segment length and
//   lane selector by lane count, four and five bits a stage), three stages
//   for area size and two 32x32 multiplies, eight stages reducing the
//   relative position modulo lane length, one output register.
//   Throughput is one beat per cycle while m_axis_tready is held high.
// Reset clears all valid bits and loads segment length 262144, lane count 4.
// When the receiver stalls the pipeline fills up stage by stage, each stage
// holding its beat; s_axis_tready drops only once every stage is occupied.
module argon2_reference_block_index (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [acbi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [acbi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [25:0] block_index, [89:26] prev_first_word, [95:90] zero
  input  logic [acbi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [25:0] previous block index, [51:26] referenced block index, [55:52] zero
  output logic [acbi_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import acbi_pkg::*;

  logic [SEG_W-1:0]   seg_q;
  logic [LANES_W-1:0] lanes_q;
  logic [LEN_W-1:0]   lane_len;

  logic  split_valid, split_ready, area_valid, area_ready;
  idx_t  idx;
  rel_t  rel;
  logic [IDX_W-1:0] prev_blk, ref_blk;

  // Configuration registers, zero stored as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SEG_RESET;
      lanes_q <= LANES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEGMENT_LENGTH: begin
          seg_q <= (cfg_data_i == '0) ? {{(SEG_W-1){1'b0}}, 1'b1} : cfg_data_i;
        end
        REG_LANE_COUNT: begin
          lanes_q <= (cfg_data_i[LANES_W-1:0] == '0) ? {{(LANES_W-1){1'b0}}, 1'b1}
                                                     : cfg_data_i[LANES_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign lane_len = {seg_q, 2'b00};

  acbi_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .seg_i   (seg_q),
    .lanes_i (lanes_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .ij_i    (s_axis_tdata[IDX_W-1:0]),
    .word_i  (s_axis_tdata[IDX_W+WORD_W-1:IDX_W]),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .idx_o   (idx)
  );

  acbi_area u_area (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seg_i      (seg_q),
    .lane_len_i (lane_len),
    .valid_i    (split_valid),
    .ready_o    (split_ready),
    .idx_i      (idx),
    .valid_o    (area_valid),
    .ready_i    (area_ready),
    .rel_o      (rel)
  );

  acbi_wrap u_wrap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lane_len_i (lane_len),
    .valid_i    (area_valid),
    .ready_o    (area_ready),
    .rel_i      (rel),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .prev_o     (prev_blk),
    .ref_o      (ref_blk)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-2*IDX_W){1'b0}}, ref_blk, prev_blk};

endmodule
